// File: src/tap_tempo_bpm_meter_macros.svh
// Assertion macros shared by the tap tempo meter modules
`ifndef TAP_TEMPO_BPM_METER_MACROS_SVH
`define TAP_TEMPO_BPM_METER_MACROS_SVH

// Property checked on every clock edge outside reset
`define TTBM_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition that must be followed by another one on the next clock edge
`define TTBM_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`endif

// File: src/ttbm_pkg.sv
// Types, codes and constants of the tap tempo meter
`timescale 1ns / 1ps

package ttbm_pkg;

    localparam int QUEUE_DEPTH = 2;

    localparam logic [15:0] MS_PER_MINUTE = 16'd60000;
    localparam int DIV_STEPS = 16;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    localparam logic [15:0] DEBOUNCE_RESET     = 16'd20;
    localparam logic [15:0] MAX_INTERVAL_RESET = 16'd1500;
    localparam logic [15:0] MIN_INTERVAL_RESET = 16'd250;

    // Command codes on the request channel
    localparam logic [1:0] CMD_TICK   = 2'd0;
    localparam logic [1:0] CMD_RESET  = 2'd1;
    localparam logic [1:0] CMD_READ   = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] REG_DEBOUNCE     = 2'd0;
    localparam logic [1:0] REG_MAX_INTERVAL = 2'd1;
    localparam logic [1:0] REG_MIN_INTERVAL = 2'd2;

    typedef struct packed {
        logic [1:0] command;
        logic       pin_level;
        logic       rising_edge;
    } req_t;

    typedef struct packed {
        logic [15:0] tempo_bpm;
        logic        tempo_ready;
        logic [1:0]  tap_phase;
    } rsp_t;

    typedef struct packed {
        logic [15:0] debounce_ms;
        logic [15:0] max_interval_ms;
        logic [15:0] min_interval_ms;
    } cfg_t;

    typedef enum logic [1:0] {
        OP_TICK,
        OP_RESET,
        OP_READ,
        OP_NOP
    } op_t;

    typedef struct packed {
        op_t  op;
        logic pin_level;
        logic rising_edge;
    } q_entry_t;

    typedef enum logic [1:0] {
        PH_RELEASED  = 2'd0,
        PH_TRIGGERED = 2'd1,
        PH_HIGH      = 2'd2,
        PH_WAIT_LOW  = 2'd3
    } phase_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_PREP,
        BK_DIV,
        BK_DONE
    } back_state_t;

    typedef struct packed {
        logic        start;
        logic [15:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic [15:0] quotient;
    } div_rsp_t;

endpackage

// File: src/ttbm_front.sv
// Request intake: registers a request and classifies its command
`timescale 1ns / 1ps

module ttbm_front
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_ready,
    input  ttbm_pkg::req_t      req,
    input  logic                q_full,
    output logic                q_push,
    output ttbm_pkg::q_entry_t  q_data
);

    logic               stage_valid_reg;
    logic               stage_valid_next;
    ttbm_pkg::q_entry_t stage_reg;
    ttbm_pkg::op_t      op_dec;
    logic               accept;

    always_comb
    begin
        unique case (req.command)
            ttbm_pkg::CMD_TICK:  op_dec = ttbm_pkg::OP_TICK;
            ttbm_pkg::CMD_RESET: op_dec = ttbm_pkg::OP_RESET;
            ttbm_pkg::CMD_READ:  op_dec = ttbm_pkg::OP_READ;
            default:             op_dec = ttbm_pkg::OP_NOP;
        endcase
    end

    assign q_push    = stage_valid_reg && !q_full;
    assign q_data    = stage_reg;
    assign req_ready = !stage_valid_reg || !q_full;
    assign accept    = req_valid && req_ready;

    always_comb
    begin
        stage_valid_next = stage_valid_reg;
        if (accept)
        begin
            stage_valid_next = 1'b1;
        end
        else if (q_push)
        begin
            stage_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else
        begin
            stage_valid_reg <= stage_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            stage_reg.op          <= op_dec;
            stage_reg.pin_level   <= req.pin_level;
            stage_reg.rising_edge <= req.rising_edge;
        end
    end

endmodule

// File: src/ttbm_queue.sv
// Small request queue between intake and execution
`timescale 1ns / 1ps
`include "tap_tempo_bpm_meter_macros.svh"

module ttbm_queue
#(
    parameter int DEPTH = ttbm_pkg::QUEUE_DEPTH
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  ttbm_pkg::q_entry_t  push_data,
    output logic                full,
    input  logic                pop,
    output ttbm_pkg::q_entry_t  pop_data,
    output logic                valid
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    ttbm_pkg::q_entry_t entries [DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        if (p == PTR_W'(DEPTH - 1))
        begin
            r = '0;
        end
        else
        begin
            r = p + PTR_W'(1);
        end
        return r;
    endfunction

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign valid    = (count_reg != '0);
    assign pop_data = entries[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries[wr_ptr_reg] <= push_data;
        end
    end

    `TTBM_ASSERT(a_no_push_full, push |-> !full, "queue push while full")
    `TTBM_ASSERT(a_no_pop_empty, pop |-> valid, "queue pop while empty")
    `TTBM_ASSERT(a_count_bound, count_reg <= CNT_W'(DEPTH), "queue count beyond depth")

endmodule

// File: src/ttbm_div.sv
// Bit-serial restoring divider: 60000 / divisor, one quotient bit per cycle
`timescale 1ns / 1ps
`include "tap_tempo_bpm_meter_macros.svh"

module ttbm_div
(
    input  logic                clk,
    input  logic                rst_n,
    input  ttbm_pkg::div_req_t  div_req,
    output ttbm_pkg::div_rsp_t  div_rsp
);

    localparam int CW = ttbm_pkg::DIV_CNT_W;

    logic          busy_reg;
    logic          busy_next;
    logic          done_reg;
    logic          done_next;
    logic [CW-1:0] cnt_reg;
    logic [CW-1:0] cnt_next;
    logic [15:0]   rem_reg;
    logic [15:0]   rem_next;
    logic [15:0]   quo_reg;
    logic [15:0]   quo_next;
    logic [15:0]   dsr_reg;
    logic [15:0]   dsr_next;
    logic [16:0]   shifted;
    logic          fits;

    assign shifted = {rem_reg, quo_reg[15]};
    assign fits    = (shifted >= {1'b0, dsr_reg});

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        if (div_req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = ttbm_pkg::MS_PER_MINUTE;
            dsr_next  = div_req.divisor;
        end
        else if (busy_reg)
        begin
            if (fits)
            begin
                rem_next = 16'(shifted - {1'b0, dsr_reg});
            end
            else
            begin
                rem_next = shifted[15:0];
            end
            quo_next = {quo_reg[14:0], fits};
            cnt_next = cnt_reg + CW'(1);
            if (cnt_reg == CW'(ttbm_pkg::DIV_STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
    end

    assign div_rsp.done     = done_reg;
    assign div_rsp.quotient = quo_reg;

    `TTBM_ASSERT(a_no_restart, div_req.start |-> !busy_reg, "divider restarted while busy")
    `TTBM_ASSERT_NEXT(a_done_pulse, done_reg, !done_reg, "divider done held past one cycle")

endmodule

// File: src/ttbm_back.sv
// Execution side: tap state machine, tempo register and response register
`timescale 1ns / 1ps
`include "tap_tempo_bpm_meter_macros.svh"

module ttbm_back
(
    input  logic                clk,
    input  logic                rst_n,
    input  ttbm_pkg::cfg_t      cfg,
    input  logic                q_valid,
    input  ttbm_pkg::q_entry_t  q_data,
    output logic                q_pop,
    output ttbm_pkg::div_req_t  div_req,
    input  ttbm_pkg::div_rsp_t  div_rsp,
    output logic                rsp_valid,
    input  logic                rsp_ready,
    output ttbm_pkg::rsp_t      rsp
);

    ttbm_pkg::back_state_t state_reg;
    ttbm_pkg::back_state_t state_next;
    ttbm_pkg::phase_t      phase_reg;
    ttbm_pkg::phase_t      phase_next;

    logic [31:0]    now_reg;
    logic [31:0]    now_next;
    logic [31:0]    tap_reg;
    logic [31:0]    tap_next;
    logic [31:0]    last_reg;
    logic [31:0]    last_next;
    logic [31:0]    elapsed_reg;
    logic [31:0]    elapsed_next;
    logic [15:0]    tempo_reg;
    logic [15:0]    tempo_next;
    logic [15:0]    ivl_reg;
    logic [15:0]    ivl_next;
    logic           out_valid_reg;
    logic           out_valid_next;
    ttbm_pkg::rsp_t out_reg;
    ttbm_pkg::rsp_t out_next;

    logic        out_free;
    logic [31:0] now_inc;
    logic [31:0] elapsed_inc;
    logic [31:0] interval;
    logic        too_long;
    logic [15:0] floored;

    assign out_free    = !out_valid_reg || rsp_ready;
    assign now_inc     = now_reg + 32'd1;
    assign elapsed_inc = elapsed_reg + 32'd1;
    assign interval    = tap_reg - last_reg;
    assign too_long    = (interval > {16'd0, cfg.max_interval_ms});
    assign floored     = (ivl_reg < cfg.min_interval_ms) ? cfg.min_interval_ms : ivl_reg;

    always_comb
    begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        now_next       = now_reg;
        tap_next       = tap_reg;
        last_next      = last_reg;
        elapsed_next   = elapsed_reg;
        tempo_next     = tempo_reg;
        ivl_next       = ivl_reg;
        out_valid_next = out_valid_reg && !rsp_ready;
        out_next       = out_reg;
        q_pop          = 1'b0;
        div_req.start   = 1'b0;
        div_req.divisor = (floored == 16'd0) ? 16'd1 : floored;

        unique case (state_reg)
            ttbm_pkg::BK_IDLE:
            begin
                if (q_valid && out_free)
                begin
                    q_pop = 1'b1;
                    out_next.tempo_bpm = 16'd0;
                    unique case (q_data.op)
                        ttbm_pkg::OP_TICK:
                        begin
                            now_next = now_inc;
                            if (q_data.rising_edge && phase_reg == ttbm_pkg::PH_RELEASED)
                            begin
                                // stamp, then triggered steps to high in the same tick
                                tap_next   = now_inc;
                                phase_next = ttbm_pkg::PH_HIGH;
                            end
                            else
                            begin
                                unique case (phase_reg)
                                    ttbm_pkg::PH_TRIGGERED:
                                    begin
                                        phase_next = ttbm_pkg::PH_HIGH;
                                    end
                                    ttbm_pkg::PH_HIGH:
                                    begin
                                        if (!q_data.pin_level)
                                        begin
                                            elapsed_next = 32'd0;
                                            phase_next   = ttbm_pkg::PH_WAIT_LOW;
                                        end
                                    end
                                    ttbm_pkg::PH_WAIT_LOW:
                                    begin
                                        elapsed_next = elapsed_inc;
                                        if (q_data.pin_level)
                                        begin
                                            phase_next = ttbm_pkg::PH_HIGH;
                                        end
                                        else if (elapsed_inc > {16'd0, cfg.debounce_ms})
                                        begin
                                            // tap complete
                                            phase_next = ttbm_pkg::PH_RELEASED;
                                            last_next  = tap_reg;
                                            if (tap_reg != 32'd0 && last_reg != 32'd0)
                                            begin
                                                if (too_long)
                                                begin
                                                    tap_next   = 32'd0;
                                                    last_next  = 32'd0;
                                                    tempo_next = 16'd0;
                                                end
                                                else
                                                begin
                                                    ivl_next   = interval[15:0];
                                                    state_next = ttbm_pkg::BK_PREP;
                                                end
                                            end
                                        end
                                    end
                                    default:
                                    begin
                                    end
                                endcase
                            end
                            out_next.tempo_ready = (tempo_next != 16'd0);
                            out_next.tap_phase   = phase_next;
                            // a tap that needs a division responds when it is done
                            out_valid_next = out_valid_next || (state_next == ttbm_pkg::BK_IDLE);
                        end
                        ttbm_pkg::OP_RESET:
                        begin
                            tempo_next           = 16'd0;
                            tap_next             = 32'd0;
                            last_next            = 32'd0;
                            phase_next           = ttbm_pkg::PH_RELEASED;
                            out_next.tempo_ready = 1'b0;
                            out_next.tap_phase   = ttbm_pkg::PH_RELEASED;
                            out_valid_next       = 1'b1;
                        end
                        ttbm_pkg::OP_READ:
                        begin
                            tempo_next           = 16'd0;
                            out_next.tempo_bpm   = tempo_reg;
                            out_next.tempo_ready = 1'b0;
                            out_next.tap_phase   = phase_reg;
                            out_valid_next       = 1'b1;
                        end
                        default:
                        begin
                            out_next.tempo_ready = (tempo_reg != 16'd0);
                            out_next.tap_phase   = phase_reg;
                            out_valid_next       = 1'b1;
                        end
                    endcase
                end
            end
            ttbm_pkg::BK_PREP:
            begin
                div_req.start = 1'b1;
                state_next    = ttbm_pkg::BK_DIV;
            end
            ttbm_pkg::BK_DIV:
            begin
                if (div_rsp.done)
                begin
                    tempo_next = div_rsp.quotient;
                    state_next = ttbm_pkg::BK_DONE;
                end
            end
            ttbm_pkg::BK_DONE:
            begin
                if (out_free)
                begin
                    out_next.tempo_bpm   = 16'd0;
                    out_next.tempo_ready = (tempo_reg != 16'd0);
                    out_next.tap_phase   = phase_reg;
                    out_valid_next       = 1'b1;
                    state_next           = ttbm_pkg::BK_IDLE;
                end
            end
            default:
            begin
                state_next = ttbm_pkg::BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ttbm_pkg::BK_IDLE;
            phase_reg     <= ttbm_pkg::PH_RELEASED;
            now_reg       <= 32'd0;
            tap_reg       <= 32'd0;
            last_reg      <= 32'd0;
            elapsed_reg   <= 32'd0;
            tempo_reg     <= 16'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            now_reg       <= now_next;
            tap_reg       <= tap_next;
            last_reg      <= last_next;
            elapsed_reg   <= elapsed_next;
            tempo_reg     <= tempo_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ivl_reg <= ivl_next;
        out_reg <= out_next;
    end

    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

    `TTBM_ASSERT(a_pop_idle, q_pop |-> (state_reg == ttbm_pkg::BK_IDLE) && out_free, "pop outside idle or with response blocked")
    `TTBM_ASSERT(a_no_trig_out, out_valid_reg |-> (out_reg.tap_phase != ttbm_pkg::PH_TRIGGERED), "triggered phase reported")
    `TTBM_ASSERT_NEXT(a_prep_div, state_reg == ttbm_pkg::BK_PREP, state_reg == ttbm_pkg::BK_DIV, "divide did not start after prep")

endmodule

// File: src/tap_tempo_bpm_meter.sv
// A request passes the front stage register, the queue and the response register in turn.
// Throughput: one request per cycle while responses are taken, except a completed tap holds
//   the back end while the bit-serial divider makes one quotient bit per cycle.
// A 2-entry queue decouples intake from execution; the response register frees intake.
// Reset (rst_n, async low): queue empty, phase released, counters, stamps and tempo zero,
//   debounce 20, max interval 1500, min interval 250.
`timescale 1ns / 1ps

module tap_tempo_bpm_meter
#(
    parameter int QUEUE_DEPTH = ttbm_pkg::QUEUE_DEPTH
)
(
    input  logic            clk,
    input  logic            rst_n,
    // request channel
    input  logic            req_valid,
    output logic            req_ready,
    input  ttbm_pkg::req_t  req,
    // response channel
    output logic            rsp_valid,
    input  logic            rsp_ready,
    output ttbm_pkg::rsp_t  rsp,
    // configuration writes
    input  logic            cfg_valid,
    output logic            cfg_ready,
    input  logic [1:0]      cfg_index,
    input  logic [15:0]     cfg_data
);

    ttbm_pkg::cfg_t     cfg_reg;
    ttbm_pkg::cfg_t     cfg_next;
    logic               q_full;
    logic               q_push;
    ttbm_pkg::q_entry_t q_push_data;
    logic               q_valid;
    logic               q_pop;
    ttbm_pkg::q_entry_t q_pop_data;
    ttbm_pkg::div_req_t div_req;
    ttbm_pkg::div_rsp_t div_rsp;

    // The user must issue config writes only while idle; the block does not enforce it. They are always taken.
    assign cfg_ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                ttbm_pkg::REG_DEBOUNCE:     cfg_next.debounce_ms     = cfg_data;
                ttbm_pkg::REG_MAX_INTERVAL: cfg_next.max_interval_ms = cfg_data;
                ttbm_pkg::REG_MIN_INTERVAL: cfg_next.min_interval_ms = cfg_data;
                default:                    cfg_next = cfg_reg;  // no register here
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.debounce_ms     <= ttbm_pkg::DEBOUNCE_RESET;
            cfg_reg.max_interval_ms <= ttbm_pkg::MAX_INTERVAL_RESET;
            cfg_reg.min_interval_ms <= ttbm_pkg::MIN_INTERVAL_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Front: registers each request and turns its command into an operation.
    ttbm_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_data    (q_push_data)
    );

    // Queue: lets the front keep taking requests while the back is dividing.
    ttbm_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_push_data),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_pop_data),
        .valid     (q_valid)
    );

    // Back: millisecond counter, tap machine, tempo and the response register.
    ttbm_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .q_valid   (q_valid),
        .q_data    (q_pop_data),
        .q_pop     (q_pop),
        .div_req   (div_req),
        .div_rsp   (div_rsp),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    // Divider: 60000 / floored interval.
    ttbm_div u_div
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .div_req (div_req),
        .div_rsp (div_rsp)
    );

endmodule
